// ===== design/json_string_unescape_decoder_macros.svh =====
// Assertion macros for the JSON string unescape decoder.
// Used by the top level; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_DECODER_MACROS_SVH
`define JSON_STRING_UNESCAPE_DECODER_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset.
`define JSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under asynchronous active-low reset.
`define JSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/jsu_pkg.sv =====
// Shared types, constants and decode functions for the JSON string unescape decoder.
// No dependencies; compiled first.
package jsu_pkg;

	localparam int CP_W = 21;

	localparam logic [CP_W-1:0] CP_BACKSLASH = 21'h5C;
	localparam logic [CP_W-1:0] CP_LOWER_U   = 21'h75;
	localparam logic [15:0]     SUR_FIRST    = 16'hD800;
	localparam logic [15:0]     SUR_LAST     = 16'hDFFF;
	localparam logic [CP_W-1:0] SUR_LOW_BASE = 21'h0DC00;
	localparam logic [CP_W-1:0] SUPP_BASE    = 21'h10000;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_HEX1  = 3'd2,
		MODE_HEX2  = 3'd3,
		MODE_HEX3  = 3'd4,
		MODE_HEX4  = 3'd5,
		MODE_ERR   = 3'd6
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] hex_accum;
		logic [15:0] pending_half;
	} state_t;

	localparam state_t STATE_RESET = '{mode: MODE_PLAIN, hex_accum: 16'h0000,
		pending_half: 16'h0000};

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [CP_W-1:0] char_out;
		logic            char_valid;
		logic            end_of_string;
		logic            string_ok;
	} res_t;

	// What one processed item asks of the output side.
	typedef struct packed {
		logic       valid;
		res_t       beat;
		logic       burst_start;
		logic [2:0] burst_last;
	} step_res_t;

	// Kept-digit write request.
	typedef struct packed {
		logic       we;
		logic [1:0] sel;
	} kept_wr_t;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [CP_W-1:0] c);
		logic [4:0] r;
		r = 5'b0_0000;
		case (c) inside
			[21'h30:21'h39]: r = {1'b1, 4'(c - 21'h30)};
			[21'h41:21'h46]: r = {1'b1, 4'(c - 21'h41 + 21'd10)};
			[21'h61:21'h66]: r = {1'b1, 4'(c - 21'h61 + 21'd10)};
			default:         r = 5'b0_0000;
		endcase
		return r;
	endfunction

	// {valid, character}
	function automatic logic [8:0] short_escape(input logic [CP_W-1:0] c);
		logic [8:0] r;
		r = 9'h000;
		unique case (c)
			21'h22:  r = {1'b1, 8'h22};
			21'h5C:  r = {1'b1, 8'h5C};
			21'h2F:  r = {1'b1, 8'h2F};
			21'h62:  r = {1'b1, 8'h08};
			21'h66:  r = {1'b1, 8'h0C};
			21'h6E:  r = {1'b1, 8'h0A};
			21'h72:  r = {1'b1, 8'h0D};
			21'h74:  r = {1'b1, 8'h09};
			default: r = 9'h000;
		endcase
		return r;
	endfunction

endpackage

// ===== design/jsu_in_if.sv =====
// Input channel of the JSON string unescape decoder: one code point per beat.
// Depends on jsu_pkg.
interface jsu_in_if;
	logic                      valid;
	logic                      ready;
	logic [jsu_pkg::CP_W-1:0]  code_point;
	logic                      last_item;

	modport source (output valid, code_point, last_item, input ready);
	modport sink   (input valid, code_point, last_item, output ready);
endinterface

// ===== design/jsu_out_if.sv =====
// Result channel of the JSON string unescape decoder.
// Depends on jsu_pkg.
interface jsu_out_if;
	logic                      valid;
	logic                      ready;
	logic [jsu_pkg::CP_W-1:0]  char_out;
	logic                      char_valid;
	logic                      end_of_string;
	logic                      string_ok;

	modport source (output valid, char_out, char_valid, end_of_string, string_ok,
		input ready);
	modport sink   (input valid, char_out, char_valid, end_of_string, string_ok,
		output ready);
endinterface

// ===== design/jsu_step.sv =====
// Combinational escape decoder: next state and result for one code point.
// Depends on jsu_pkg.
module jsu_step (
	input  jsu_pkg::state_t            st,
	input  logic [jsu_pkg::CP_W-1:0]   cp,
	input  logic                       last,
	output jsu_pkg::state_t            nxt,
	output jsu_pkg::kept_wr_t          kept_wr,
	output jsu_pkg::step_res_t         res
);

	jsu_pkg::state_t            take_nxt;
	logic                       put;
	logic [jsu_pkg::CP_W-1:0]   put_char;
	logic [4:0]                 hex;
	logic [8:0]                 esc;
	logic [15:0]                acc_new;
	logic                       is_sur;
	logic                       half_pend;
	logic [jsu_pkg::CP_W-1:0]   joined;

	assign hex       = jsu_pkg::hex_digit(cp);
	assign esc       = jsu_pkg::short_escape(cp);
	assign acc_new   = {st.hex_accum[11:0], hex[3:0]};
	assign is_sur    = (acc_new >= jsu_pkg::SUR_FIRST) && (acc_new <= jsu_pkg::SUR_LAST);
	assign half_pend = (st.pending_half != 16'h0000);
	// high half minus D800 is just its low 11 bits
	assign joined    = {st.pending_half[10:0], 10'b0}
		+ ({5'b0, acc_new} - jsu_pkg::SUR_LOW_BASE) + jsu_pkg::SUPP_BASE;

	// next state after taking the code point
	always_comb begin
		take_nxt = st;
		put      = 1'b0;
		put_char = '0;
		kept_wr  = '0;
		unique case (st.mode)
			jsu_pkg::MODE_PLAIN: begin
				if (cp == jsu_pkg::CP_BACKSLASH) begin
					take_nxt.mode = jsu_pkg::MODE_ESC;
				end else if (half_pend) begin
					take_nxt.mode = jsu_pkg::MODE_ERR;
				end else begin
					put      = 1'b1;
					put_char = cp;
				end
			end
			jsu_pkg::MODE_ESC: begin
				if (cp == jsu_pkg::CP_LOWER_U) begin
					take_nxt.mode      = jsu_pkg::MODE_HEX1;
					take_nxt.hex_accum = 16'h0000;
				end else if (half_pend || !esc[8]) begin
					take_nxt.mode = jsu_pkg::MODE_ERR;
				end else begin
					put           = 1'b1;
					put_char      = {13'b0, esc[7:0]};
					take_nxt.mode = jsu_pkg::MODE_PLAIN;
				end
			end
			jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
				if (!hex[4]) begin
					take_nxt.mode = jsu_pkg::MODE_ERR;
				end else begin
					kept_wr.we         = 1'b1;
					kept_wr.sel        = 2'(st.mode - jsu_pkg::MODE_HEX1);
					take_nxt.hex_accum = acc_new;
					take_nxt.mode      = jsu_pkg::mode_t'(st.mode + 3'd1);
				end
			end
			jsu_pkg::MODE_HEX4: begin
				if (!hex[4]) begin
					take_nxt.mode = jsu_pkg::MODE_ERR;
				end else begin
					take_nxt.hex_accum = acc_new;
					take_nxt.mode      = jsu_pkg::MODE_PLAIN;
					if (is_sur) begin
						if (!half_pend) begin
							take_nxt.pending_half = acc_new;
						end else begin
							put                   = 1'b1;
							put_char              = joined;
							take_nxt.pending_half = 16'h0000;
						end
					end else if (half_pend) begin
						take_nxt.mode = jsu_pkg::MODE_ERR;
					end else begin
						put      = 1'b1;
						put_char = {5'b0, acc_new};
					end
				end
			end
			default: take_nxt.mode = jsu_pkg::MODE_ERR;
		endcase
	end

	// result beat and string close
	always_comb begin
		nxt = last ? jsu_pkg::STATE_RESET : take_nxt;
		res = '0;
		res.beat.char_out   = put_char;
		res.beat.char_valid = put;
		res.valid           = put;
		if (last) begin
			res.valid              = 1'b1;
			res.beat.end_of_string = 1'b1;
			res.beat.string_ok     = (take_nxt.mode == jsu_pkg::MODE_PLAIN);
			unique case (take_nxt.mode)
				jsu_pkg::MODE_ESC: begin
					res.beat.char_out   = jsu_pkg::CP_BACKSLASH;
					res.beat.char_valid = 1'b1;
				end
				jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
				jsu_pkg::MODE_HEX4: begin
					// backslash now, then 'u' and the kept digits
					res.beat.char_out      = jsu_pkg::CP_BACKSLASH;
					res.beat.char_valid    = 1'b1;
					res.beat.end_of_string = 1'b0;
					res.burst_start        = 1'b1;
					res.burst_last         = 3'(take_nxt.mode - 3'd1);
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== design/json_string_unescape_decoder.sv =====
// JSON string unescape decoder, top level: input stage, state, result register, replay.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_step and the assertion macros.
//
// Usage
//  - items: one code point of a JSON string body per beat, last_item on the final one.
//  - results: decoded code points. The final beat of a string has end_of_string set
//    and string_ok tells whether the escapes were well formed. When the final item
//    leaves nothing to show, an end marker with char_valid low closes the string.
//  - Path: an item beat passes the input register, then the result register.
//  - Throughput: one item per cycle unless stalled; items that only open an escape give no beat.
//    A string ending inside an unfinished \u escape replays backslash, 'u' and the
//    digits taken, one beat a cycle while the result register is free: up to five
//    beats, set by the replay counter that drives the single result register.
//  - Stall: while the result register holds a beat not yet taken, or a replay runs,
//    the input stage waits; items.ready drops once the input register is full too.
//  - Reset (arst_n low): mode, pending surrogate half, replay and valid flags are
//    cleared; the block starts a fresh string. Kept digits are never cleared.
`include "json_string_unescape_decoder_macros.svh"

module json_string_unescape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	jsu_in_if.sink      items,
	jsu_out_if.source   results
);

	// input stage
	logic                       in_vld_s1;
	logic [jsu_pkg::CP_W-1:0]   cp_s1;
	logic                       last_s1;

	// decoder state
	jsu_pkg::state_t            st_q;
	jsu_pkg::state_t            st_nxt;
	jsu_pkg::kept_wr_t          kept_wr;
	jsu_pkg::step_res_t         step_res;
	logic [jsu_pkg::CP_W-1:0]   kept_q [3];

	// replay of an unfinished \u escape
	logic                       burst_act_q;
	logic [2:0]                 burst_idx_q;
	logic [2:0]                 burst_last_q;
	jsu_pkg::res_t              burst_beat;
	logic [1:0]                 kept_rd;

	// result register
	logic                       out_vld_q;
	jsu_pkg::res_t              out_q;

	logic                       out_free;
	logic                       advance;
	logic                       in_take;

	assign out_free = !out_vld_q || results.ready;
	assign advance  = in_vld_s1 && !burst_act_q && out_free;
	assign in_take  = items.valid && items.ready;

	assign items.ready = !in_vld_s1 || advance;

	jsu_step u_step (
		.st      (st_q),
		.cp      (cp_s1),
		.last    (last_s1),
		.nxt     (st_nxt),
		.kept_wr (kept_wr),
		.res     (step_res)
	);

	// replay beat: index 1 is 'u', 2..4 are the kept digits
	assign kept_rd = 2'(burst_idx_q - 3'd2);
	always_comb begin
		burst_beat               = '0;
		burst_beat.char_valid    = 1'b1;
		burst_beat.end_of_string = (burst_idx_q == burst_last_q);
		burst_beat.char_out      = (burst_idx_q == 3'd1) ? jsu_pkg::CP_LOWER_U
			: kept_q[kept_rd];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1    <= 1'b0;
			st_q         <= jsu_pkg::STATE_RESET;
			burst_act_q  <= 1'b0;
			burst_idx_q  <= 3'd0;
			burst_last_q <= 3'd0;
			out_vld_q    <= 1'b0;
		end else begin
			if (in_take) begin
				in_vld_s1 <= 1'b1;
			end else if (advance) begin
				in_vld_s1 <= 1'b0;
			end

			if (advance) begin
				st_q <= st_nxt;
			end

			if (burst_act_q && out_free) begin
				burst_idx_q <= burst_idx_q + 3'd1;
				if (burst_idx_q == burst_last_q) begin
					burst_act_q <= 1'b0;
				end
			end else if (advance && step_res.burst_start) begin
				burst_act_q  <= 1'b1;
				burst_idx_q  <= 3'd1;
				burst_last_q <= step_res.burst_last;
			end

			if (burst_act_q && out_free) begin
				out_vld_q <= 1'b1;
			end else if (advance && step_res.valid) begin
				out_vld_q <= 1'b1;
			end else if (out_free) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			cp_s1   <= items.code_point;
			last_s1 <= items.last_item;
		end
		if (advance && kept_wr.we) begin
			kept_q[kept_wr.sel] <= cp_s1;
		end
		if (burst_act_q && out_free) begin
			out_q <= burst_beat;
		end else if (advance && step_res.valid) begin
			out_q <= step_res.beat;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.char_out      = out_q.char_out;
	assign results.char_valid    = out_q.char_valid;
	assign results.end_of_string = out_q.end_of_string;
	assign results.string_ok     = out_q.string_ok;

	// checks
	`JSU_ASSERT_IMP(a_replay_holds_input, clk, arst_n, burst_act_q, !advance, "item taken during replay")
	`JSU_ASSERT_NXT(a_close_resets, clk, arst_n, advance && last_s1, st_q == jsu_pkg::STATE_RESET, "state not reset after close")
	`JSU_ASSERT_IMP(a_marker_closes, clk, arst_n, out_vld_q && !out_q.char_valid, out_q.end_of_string, "empty beat mid-string")
	`JSU_ASSERT_IMP(a_replay_bound, clk, arst_n, burst_act_q, (burst_idx_q <= burst_last_q) && (burst_last_q <= 3'd4), "replay index out of range")

endmodule

// ===== bench/tb_json_string_unescape_decoder.sv =====
// Self-checking bench for json_string_unescape_decoder: code point beats in, decoded beats out.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the decoder RTL; reads no files.
module tb_json_string_unescape_decoder;

	localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
	localparam int RANDOM_ITEMS   = 160;
	localparam int CALM_TAIL      = 40;    // last random items run with no idling
	localparam int MAX_SHOWN      = 10;
	localparam int DRAIN_CYCLES   = 12;    // input and result registers plus the longest replay, with margin

	// Characters that may follow a backslash as a short escape.
	localparam logic [jsu_pkg::CP_W-1:0] ESC_SOURCES [8] = '{21'h22, 21'h5C, 21'h2F, 21'h62,
		21'h66, 21'h6E, 21'h72, 21'h74};

	// Decoder model plus the queue of beats it says must come out, oldest first.
	class char_board;
		jsu_pkg::mode_t           mode;
		logic [15:0]              accum;
		logic [15:0]              half;
		logic [jsu_pkg::CP_W-1:0] digits [3];
		jsu_pkg::res_t            chars_due [$];
		int                       n_fail;

		function new();
			clear();
			n_fail = 0;
		endfunction

		function void clear();
			mode  = jsu_pkg::MODE_PLAIN;
			accum = '0;
			half  = '0;
		endfunction

		static function int digit_value(logic [jsu_pkg::CP_W-1:0] c);
			if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
			if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
			if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
			return -1;
		endfunction

		static function int escape_target(logic [jsu_pkg::CP_W-1:0] c);
			case (c)
				21'h22:  return 'h22;
				21'h5C:  return 'h5C;
				21'h2F:  return 'h2F;
				21'h62:  return 'h08;
				21'h66:  return 'h0C;
				21'h6E:  return 'h0A;
				21'h72:  return 'h0D;
				21'h74:  return 'h09;
				default: return -1;
			endcase
		endfunction

		function void emit(logic [jsu_pkg::CP_W-1:0] ch);
			jsu_pkg::res_t r;
			r = '0;
			r.char_out   = ch;
			r.char_valid = 1'b1;
			chars_due = {chars_due, r};
		endfunction

		// Advance the model by one accepted code point and queue what it yields.
		function void take_code_point(logic [jsu_pkg::CP_W-1:0] c, logic last);
			int            v;
			int            first;
			int            i;
			logic          ok;
			int unsigned   joined;
			jsu_pkg::res_t marker;
			first = chars_due.size();
			ok    = 1'b1;
			case (mode)
				jsu_pkg::MODE_PLAIN: begin
					if (c == jsu_pkg::CP_BACKSLASH) mode = jsu_pkg::MODE_ESC;
					else if (half != 0) mode = jsu_pkg::MODE_ERR;
					else emit(c);
				end
				jsu_pkg::MODE_ESC: begin
					if (c == jsu_pkg::CP_LOWER_U) begin
						mode  = jsu_pkg::MODE_HEX1;
						accum = '0;
					end else if (half != 0) begin
						mode = jsu_pkg::MODE_ERR;
					end else begin
						v = escape_target(c);
						if (v < 0) begin
							mode = jsu_pkg::MODE_ERR;
						end else begin
							emit(jsu_pkg::CP_W'(v));
							mode = jsu_pkg::MODE_PLAIN;
						end
					end
				end
				jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
				jsu_pkg::MODE_HEX4: begin
					v = digit_value(c);
					if (v < 0) begin
						mode = jsu_pkg::MODE_ERR;
					end else begin
						if (mode != jsu_pkg::MODE_HEX4)
							digits[int'(mode) - int'(jsu_pkg::MODE_HEX1)] = c;
						accum = {accum[11:0], 4'(v)};
						if (mode != jsu_pkg::MODE_HEX4) begin
							mode = jsu_pkg::mode_t'(mode + 3'd1);
						end else begin
							mode = jsu_pkg::MODE_PLAIN;
							if (accum >= jsu_pkg::SUR_FIRST && accum <= jsu_pkg::SUR_LAST) begin
								if (half == 0) begin
									half = accum;
								end else begin
									// any two halves join, mismatched ones wrap
									joined = ((32'(half) - 32'(jsu_pkg::SUR_FIRST)) << 10)
										+ (32'(accum) - 32'(jsu_pkg::SUR_LOW_BASE))
										+ 32'(jsu_pkg::SUPP_BASE);
									emit(joined[jsu_pkg::CP_W-1:0]);
									half = '0;
								end
							end else if (half != 0) begin
								mode = jsu_pkg::MODE_ERR;
							end else begin
								emit(jsu_pkg::CP_W'(accum));
							end
						end
					end
				end
				default: mode = jsu_pkg::MODE_ERR;
			endcase
			if (!last) return;

			// close the string: replay what an unfinished escape swallowed
			if (mode == jsu_pkg::MODE_ESC) begin
				emit(jsu_pkg::CP_BACKSLASH);
				ok = 1'b0;
			end else if (mode >= jsu_pkg::MODE_HEX1 && mode <= jsu_pkg::MODE_HEX4) begin
				emit(jsu_pkg::CP_BACKSLASH);
				emit(jsu_pkg::CP_LOWER_U);
				for (i = 0; i < int'(mode) - int'(jsu_pkg::MODE_HEX1); i++) emit(digits[i]);
				ok = 1'b0;
			end else if (mode != jsu_pkg::MODE_PLAIN) begin
				ok = 1'b0;
			end
			if (chars_due.size() == first) begin
				marker = '0;
				chars_due = {chars_due, marker};
			end
			chars_due[chars_due.size() - 1].end_of_string = 1'b1;
			chars_due[chars_due.size() - 1].string_ok     = ok;
			clear();
		endfunction

		function void report(string what, jsu_pkg::res_t got, jsu_pkg::res_t want);
			n_fail++;
			if (n_fail <= MAX_SHOWN)
				$display("ERROR %s: char %h valid %b end %b ok %b; want %h valid %b end %b ok %b",
					what, got.char_out, got.char_valid, got.end_of_string, got.string_ok,
					want.char_out, want.char_valid, want.end_of_string, want.string_ok);
		endfunction

		function void match_char_beat(jsu_pkg::res_t got);
			jsu_pkg::res_t want;
			if (chars_due.size() == 0) begin
				report("unexpected beat", got, '0);
				return;
			end
			want = chars_due.pop_front();
			if (got.char_out !== want.char_out || got.char_valid !== want.char_valid ||
				got.end_of_string !== want.end_of_string || got.string_ok !== want.string_ok)
				report("mismatch", got, want);
		endfunction

		function void close_out();
			if (chars_due.size() != 0) begin
				n_fail++;
				$display("ERROR %0d expected beats never arrived", chars_due.size());
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	jsu_in_if  item_bus ();
	jsu_out_if char_bus ();

	json_string_unescape_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_bus),
		.results (char_bus)
	);

	char_board                board;
	logic [jsu_pkg::CP_W-1:0] text [$];     // code points of the string being built
	bit                       idling;       // random gaps on both sides while set
	int                       random_sent;
	int                       quiet_cycles;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: count edges at which neither side moves a beat.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (char_bus.valid && char_bus.ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// One code point beat; the predictor sees it at the edge it is taken.
	task automatic send_item(logic [jsu_pkg::CP_W-1:0] cp, logic last);
		if (idling && $urandom_range(0, 4) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_bus.valid      <= 1'b1;
		item_bus.code_point <= cp;
		item_bus.last_item  <= last;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		board.take_code_point(cp, last);
	endtask

	// Whole string, last flag on the final code point.
	task automatic send_text();
		int i;
		for (i = 0; i < text.size(); i++) send_item(text[i], i == text.size() - 1);
		text.delete();
	endtask

	// Result side: check every beat taken, stall in short bursts while idling is on.
	task automatic drain_results();
		int            hold;
		jsu_pkg::res_t got;
		hold = 0;
		forever begin
			@(posedge clk);
			if (char_bus.valid && char_bus.ready) begin
				got = {char_bus.char_out, char_bus.char_valid, char_bus.end_of_string,
					char_bus.string_ok};
				board.match_char_beat(got);
			end
			if (hold > 0) begin
				hold--;
				char_bus.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				hold = int'($urandom_range(1, 3)) - 1;
				char_bus.ready <= 1'b0;
			end else begin
				char_bus.ready <= 1'b1;
			end
		end
	endtask

	function automatic logic [jsu_pkg::CP_W-1:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return 21'h30 + jsu_pkg::CP_W'(n);
		return ($urandom_range(0, 1) ? 21'h61 : 21'h41) + jsu_pkg::CP_W'(n) - 21'd10;
	endfunction

	function automatic void push_unicode(logic [15:0] v);
		text = {text, jsu_pkg::CP_BACKSLASH, jsu_pkg::CP_LOWER_U};
		text = {text, hex_char(v[15:12]), hex_char(v[11:8])};
		text = {text, hex_char(v[7:4]), hex_char(v[3:0])};
	endfunction

	// Anything but a backslash; half the time printable ASCII, else the full range.
	function automatic logic [jsu_pkg::CP_W-1:0] plain_char();
		logic [jsu_pkg::CP_W-1:0] c;
		if ($urandom_range(0, 1)) c = jsu_pkg::CP_W'($urandom_range(32'h20, 32'h7E));
		else c = jsu_pkg::CP_W'($urandom_range(0, 32'h10FFFF));
		if (c == jsu_pkg::CP_BACKSLASH) c = 21'h5B;
		return c;
	endfunction

	function automatic logic [15:0] bmp_value();
		logic [15:0] v;
		v = 16'($urandom_range(0, 16'hFFFF));
		if (v >= jsu_pkg::SUR_FIRST && v <= jsu_pkg::SUR_LAST) v ^= 16'h8000;
		return v;
	endfunction

	function automatic void push_short_escape();
		text = {text, jsu_pkg::CP_BACKSLASH, ESC_SOURCES[$urandom_range(0, 7)]};
	endfunction

	// Mostly well-formed escapes with random content, some broken ones and noise.
	function automatic void build_random_text();
		int                       n;
		int                       r;
		int                       k;
		logic [jsu_pkg::CP_W-1:0] c;
		n = $urandom_range(1, 6);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				text = {text, plain_char()};
			end else if (r < 45) begin
				push_short_escape();
			end else if (r < 60) begin
				push_unicode(bmp_value());
			end else if (r < 78) begin
				// proper pair: high half then low half
				push_unicode(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
				push_unicode(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
			end else if (r < 84) begin
				// any two halves, in any order
				push_unicode(16'hD800 + 16'($urandom_range(0, 16'h7FF)));
				push_unicode(16'hD800 + 16'($urandom_range(0, 16'h7FF)));
			end else if (r < 88) begin
				// half left waiting, then something that is not a half
				push_unicode(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
				case ($urandom_range(0, 2))
					0:       text = {text, plain_char()};
					1:       push_short_escape();
					default: push_unicode(bmp_value());
				endcase
			end else if (r < 92) begin
				c = jsu_pkg::CP_W'($urandom_range(0, 32'h7F));
				if (c == jsu_pkg::CP_LOWER_U || char_board::escape_target(c) >= 0) c = 21'h78;
				text = {text, jsu_pkg::CP_BACKSLASH, c};
			end else if (r < 96) begin
				// bad hex digit after zero to three good ones
				text = {text, jsu_pkg::CP_BACKSLASH, jsu_pkg::CP_LOWER_U};
				k = $urandom_range(0, 3);
				repeat (k) text = {text, hex_char(4'($urandom_range(0, 15)))};
				c = jsu_pkg::CP_W'($urandom_range(0, 32'h7F));
				if (char_board::digit_value(c) >= 0) c = 21'h67;
				text = {text, c};
			end else begin
				if ($urandom_range(0, 1)) text = {text, jsu_pkg::CP_BACKSLASH};
				else text = {text, jsu_pkg::CP_W'($urandom_range(0, 32'h10FFFF))};
			end
		end
		// cut some strings short so they end inside an escape or after a half
		if ($urandom_range(0, 99) < 15) begin
			k = $urandom_range(1, text.size());
			text = text[0:k-1];
		end
	endfunction

	initial begin
		item_bus.valid      = 1'b0;
		item_bus.code_point = '0;
		item_bus.last_item  = 1'b0;
		char_bus.ready      = 1'b0;
		arst_n              = 1'b0;
		idling              = 1'b1;
		random_sent         = 0;
		board               = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		fork
			drain_results();
		join_none

		// Directed strings.
		// field extremes, plain pass-through
		text = '{21'h10FFFF, 21'h000000};
		send_text();
		// short escape closing the string
		text = '{jsu_pkg::CP_BACKSLASH, 21'h74};
		send_text();
		// dangling backslash: replayed, string fails
		text = '{jsu_pkg::CP_BACKSLASH};
		send_text();
		// \u with no digits yet
		text = '{jsu_pkg::CP_BACKSLASH, jsu_pkg::CP_LOWER_U};
		send_text();
		// \u with three mixed-case digits: five replay beats
		text = '{jsu_pkg::CP_BACKSLASH, jsu_pkg::CP_LOWER_U, 21'h61, 21'h42, 21'h63};
		send_text();
		// lone high half at the end is dropped, string still good
		text = '{jsu_pkg::CP_BACKSLASH, jsu_pkg::CP_LOWER_U, 21'h44, 21'h38, 21'h33, 21'h64};
		send_text();
		// unknown escape, then plain text swallowed by the error state
		text = '{jsu_pkg::CP_BACKSLASH, 21'h78, 21'h61};
		send_text();

		// Random strings; the tail runs with both sides flat out.
		while (random_sent < RANDOM_ITEMS) begin
			idling = (random_sent < RANDOM_ITEMS - CALM_TAIL);
			build_random_text();
			random_sent += text.size();
			send_text();
		end
		item_bus.valid <= 1'b0;

		while (board.chars_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.close_out();
		if (board.n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
